[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcdws_pkg.sv]
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, constants and helpers of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    // Display line length and width of the remaining-character count
    localparam int LINE_CHARS = 16;
    localparam int REM_W      = $clog2(LINE_CHARS + 1);

    // Request opcodes
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_CHAR = 2'd2;
    localparam logic [1:0] OP_TEXT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SHORT_WAIT = 2'd0;
    localparam logic [1:0] CFG_LONG_WAIT  = 2'd1;
    localparam logic [1:0] CFG_CHAR_WAIT  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] SHORT_WAIT_RST = 16'd50;
    localparam logic [15:0] LONG_WAIT_RST  = 16'd2000;
    localparam logic [15:0] CHAR_WAIT_RST  = 16'd40;

    // Power-on sequence timing and bytes
    localparam logic [15:0] INIT_WAIT_US = 16'd15000;
    localparam logic [15:0] RAW1_WAIT_US = 16'd5000;
    localparam logic [15:0] RAW2_WAIT_US = 16'd150;
    localparam logic [7:0]  CMD_FUNC_SET = 8'h38;
    localparam logic [7:0]  CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0]  CMD_ENTRY    = 8'h06;
    localparam logic [7:0]  CMD_CLEAR    = 8'h01;
    localparam logic [7:0]  CMD_LONG_MSK = 8'hFC;
    localparam logic [7:0]  CMD_DDRAM    = 8'h80;
    localparam logic [7:0]  ROW1_OFFSET  = 8'h40;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;

    // Init sequence steps
    localparam int          INIT_STEPS  = 7;
    localparam int          STEP_W      = $clog2(INIT_STEPS);
    localparam logic [STEP_W-1:0] STEP_WAIT   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_RAW1   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_RAW2   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_FUNC   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_DISP   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_ENTRY  = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(INIT_STEPS - 1);

    // Kind of result beat the datapath builds
    typedef enum logic [2:0] {
        K_INIT,
        K_CMD,
        K_CHAR,
        K_POS,
        K_TCHAR,
        K_PAD
    } t_kind;

    // Controller to datapath command
    typedef struct packed {
        logic              load;   // latch the accepted input beat
        logic              plan;   // evaluate text item and update string state
        logic              emit;   // load a result beat into the output register
        t_kind             kind;
        logic [STEP_W-1:0] step;
        logic              last;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       out_free;
        logic       do_pos;
        logic       do_char;
        logic       do_pad;
        logic       rem_zero;
        logic       rem_one;
    } t_dp_status;

    // Instruction settle time: clear and home take the long wait
    function automatic logic [15:0] cmd_wait(input logic [7:0] cmd,
                                             input logic [15:0] short_w,
                                             input logic [15:0] long_w);
        return ((cmd & CMD_LONG_MSK) != 8'h00) ? short_w : long_w;
    endfunction

endpackage

[hw/rtl/lcdws_datapath.sv]
// ----------------------------------------------------------------------------
// lcdws_datapath
// Configuration, item latch, string state and output beat register.
// ----------------------------------------------------------------------------
module lcdws_datapath
    import lcdws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic [15:0] i_item_data,
    input  logic [1:0]  i_item_op,
    input  logic        i_item_last,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_out_strobe,
    output logic        o_out_rs,
    output logic [7:0]  o_out_data,
    output logic [15:0] o_out_wait,
    output logic        o_out_last
);

    // Configuration registers
    logic [15:0] r_short_wait, r_long_wait, r_char_wait;

    // Latched item
    logic [1:0] r_op;
    logic [7:0] r_byte;
    logic [1:0] r_row;
    logic [4:0] r_col;
    logic       r_fill;
    logic       r_last;

    // String state and plan flags
    logic             r_str_active, r_str_term, r_str_rej;
    logic [REM_W-1:0] r_rem;
    logic             r_do_pos, r_do_char, r_do_pad;

    // Output beat
    logic        r_o_valid, r_o_strobe, r_o_rs, r_o_last;
    logic [7:0]  r_o_data;
    logic [15:0] r_o_wait;

    // Plan evaluation
    logic             p_rej, p_term, p_live, p_nul, p_char;
    logic [REM_W-1:0] p_rem0, p_rem1;
    logic [7:0]       pos_byte;

    // Beat under construction
    logic        b_strobe, b_rs;
    logic [7:0]  b_data;
    logic [15:0] b_wait;
    logic        out_free;

    assign out_free = !r_o_valid || i_out_ready;

    // Evaluate the text item against the string state
    always_comb begin
        if (!r_str_active) begin
            p_rej  = (32'(r_col) > 32'(LINE_CHARS - 1)) || (r_row > 2'd1);
            p_term = 1'b0;
            p_rem0 = p_rej ? '0 : (r_fill ? REM_W'(LINE_CHARS)
                                          : REM_W'(LINE_CHARS) - REM_W'(r_col));
        end else begin
            p_rej  = r_str_rej;
            p_term = r_str_term;
            p_rem0 = r_rem;
        end
        p_live = !p_rej && !p_term;
        p_nul  = (r_byte == 8'h00);
        p_char = p_live && !p_nul && (p_rem0 != '0);
        p_rem1 = p_rem0 - REM_W'(p_char);
    end

    assign pos_byte = CMD_DDRAM | (((r_row == 2'd1) ? ROW1_OFFSET : 8'h00) + 8'(r_col));

    // Build the result beat for the requested kind
    always_comb begin
        b_strobe = 1'b1;
        b_rs     = 1'b0;
        b_data   = 8'h00;
        b_wait   = 16'h0000;
        case (i_cmd.kind)
            K_INIT: begin
                case (i_cmd.step)
                    STEP_WAIT: begin
                        b_strobe = 1'b0;
                        b_wait   = INIT_WAIT_US;
                    end
                    STEP_RAW1: begin
                        b_data = CMD_FUNC_SET;
                        b_wait = RAW1_WAIT_US;
                    end
                    STEP_RAW2: begin
                        b_data = CMD_FUNC_SET;
                        b_wait = RAW2_WAIT_US;
                    end
                    STEP_FUNC:  b_data = CMD_FUNC_SET;
                    STEP_DISP:  b_data = CMD_DISP_ON;
                    STEP_ENTRY: b_data = CMD_ENTRY;
                    default:    b_data = CMD_CLEAR;
                endcase
                if (i_cmd.step > STEP_RAW2) begin
                    b_wait = cmd_wait(b_data, r_short_wait, r_long_wait);
                end
            end
            K_CMD: begin
                b_data = r_byte;
                b_wait = cmd_wait(r_byte, r_short_wait, r_long_wait);
            end
            K_POS: begin
                b_data = pos_byte;
                b_wait = cmd_wait(pos_byte, r_short_wait, r_long_wait);
            end
            K_PAD: begin
                b_rs   = 1'b1;
                b_data = CHAR_SPACE;
                b_wait = r_char_wait;
            end
            default: begin
                b_rs   = 1'b1;
                b_data = r_byte;
                b_wait = r_char_wait;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_wait <= SHORT_WAIT_RST;
            r_long_wait  <= LONG_WAIT_RST;
            r_char_wait  <= CHAR_WAIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SHORT_WAIT: r_short_wait <= i_cfg_wdata;
                CFG_LONG_WAIT:  r_long_wait  <= i_cfg_wdata;
                CFG_CHAR_WAIT:  r_char_wait  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item_op;
            r_byte <= i_item_data[7:0];
            r_row  <= i_item_data[9:8];
            r_col  <= i_item_data[14:10];
            r_fill <= i_item_data[15];
            r_last <= i_item_last;
        end
    end

    // Update string state: plan, then drain flags and count while emitting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str_active <= 1'b0;
            r_str_term   <= 1'b0;
            r_str_rej    <= 1'b0;
            r_rem        <= '0;
            r_do_pos     <= 1'b0;
            r_do_char    <= 1'b0;
            r_do_pad     <= 1'b0;
        end else if (i_cmd.plan) begin
            r_str_active <= !r_last;
            r_str_term   <= !r_last && (p_term || (p_live && p_nul));
            r_str_rej    <= !r_last && p_rej;
            r_rem        <= p_rem1;
            r_do_pos     <= !r_str_active && !p_rej;
            r_do_char    <= p_char;
            r_do_pad     <= p_live && (p_nul || r_last);
        end else if (i_cmd.emit) begin
            case (i_cmd.kind)
                K_POS:   r_do_pos  <= 1'b0;
                K_TCHAR: r_do_char <= 1'b0;
                K_PAD:   r_rem     <= r_rem - REM_W'(1);
                default: ;
            endcase
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_strobe <= b_strobe;
            r_o_rs     <= b_rs;
            r_o_data   <= b_data;
            r_o_wait   <= b_wait;
            r_o_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_strobe = r_o_strobe;
    assign o_out_rs     = r_o_rs;
    assign o_out_data   = r_o_data;
    assign o_out_wait   = r_o_wait;
    assign o_out_last   = r_o_last;

    assign o_sts.op       = r_op;
    assign o_sts.out_free = out_free;
    assign o_sts.do_pos   = r_do_pos;
    assign o_sts.do_char  = r_do_char;
    assign o_sts.do_pad   = r_do_pad;
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.rem_one  = (r_rem == REM_W'(1));

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_rem_bound, 32'(r_rem) <= LINE_CHARS, "remaining count above line length")
    `ASSERT_IMPL(a_pad_nonzero, i_cmd.emit && (i_cmd.kind == K_PAD), r_rem != '0, "pad with empty count")
    `ASSERT_IMPL(a_rej_empty, r_str_rej, r_rem == '0, "rejected string holds a count")

endmodule

[hw/rtl/lcdws_ctrl.sv]
// ----------------------------------------------------------------------------
// lcdws_ctrl
// Sequencer state machine: accepts one request and steps out its beats.
// ----------------------------------------------------------------------------
module lcdws_ctrl
    import lcdws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_SINGLE,
        S_TEXT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ready, n_ready;
    logic              accept, pad_left;

    assign accept   = i_in_valid && r_ready;
    assign pad_left = i_sts.do_pad && !i_sts.rem_zero;

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.kind = K_CMD;
        o_cmd.step = r_step;
        o_cmd.load = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_INIT: begin
                        n_state = S_INIT;
                        n_step  = STEP_WAIT;
                    end
                    OP_TEXT: begin
                        o_cmd.plan = 1'b1;
                        n_state    = S_TEXT;
                    end
                    default: n_state = S_SINGLE;
                endcase
            end
            S_INIT: begin
                o_cmd.kind = K_INIT;
                o_cmd.last = (r_step == STEP_LAST);
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_step     = r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) n_state = S_IDLE;
                end
            end
            S_SINGLE: begin
                o_cmd.kind = (i_sts.op == OP_CMD) ? K_CMD : K_CHAR;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TEXT: begin
                if (i_sts.do_pos) begin
                    o_cmd.kind = K_POS;
                    o_cmd.last = !i_sts.do_char && !pad_left;
                    o_cmd.emit = i_sts.out_free;
                end else if (i_sts.do_char) begin
                    o_cmd.kind = K_TCHAR;
                    o_cmd.last = !pad_left;
                    o_cmd.emit = i_sts.out_free;
                end else if (pad_left) begin
                    o_cmd.kind = K_PAD;
                    o_cmd.last = i_sts.rem_one;
                    o_cmd.emit = i_sts.out_free;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // Hold state, init step and input ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_WAIT;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_one_item, accept, !r_ready, "second item taken while busy")
    `ASSERT_IMPL(a_emit_free, o_cmd.emit, i_sts.out_free, "beat loaded into full output register")
    `ASSERT_NEXT(a_last_ends, o_cmd.emit && o_cmd.last, !o_cmd.emit, "beat after final beat of item")

endmodule

[hw/rtl/char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns requests into timed 8-bit character LCD bus writes.
// ----------------------------------------------------------------------------
// One request is taken at a time. After a request is accepted, a decode
// state decodes it (and evaluates the string state for a text item), then
// one result beat is loaded per cycle into the single output register
// while that register is free. The input is ready for the next request
// once the sequencer is back in idle: after init (7 beats), a command or
// a character (1 beat), or a text item (0 to 17 beats), which first finds
// nothing left to send. A stall on the output side, holding a loaded beat,
// delays the return to idle. Each beat carries an enable flag, the
// register select, the bus byte and the hold-off in microseconds.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer
    import lcdws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // payload_byte[7:0], row[9:8], column[14:10], fill_line[15]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    input  logic        s_axis_tlast,
    // bus write stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // bus_data[7:0], wait_us[23:8]
    output logic [1:0]  m_axis_tuser,  // strobe_res[0], register_select[1]
    output logic        m_axis_tlast
);

    t_ctrl_cmd   cmd;
    t_dp_status  sts;
    logic        out_strobe, out_rs;
    logic [7:0]  out_data;
    logic [15:0] out_wait;

    // Sequencer control
    lcdws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath and output register
    lcdws_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_data  (s_axis_tdata),
        .i_item_op    (s_axis_tuser),
        .i_item_last  (s_axis_tlast),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_strobe (out_strobe),
        .o_out_rs     (out_rs),
        .o_out_data   (out_data),
        .o_out_wait   (out_wait),
        .o_out_last   (m_axis_tlast)
    );

    // Pack output beat
    assign m_axis_tdata = {out_wait, out_data};
    assign m_axis_tuser = {out_rs, out_strobe};

endmodule

[bench/tb_char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer
// Self-checking bench for the character LCD write sequencer. A behavioral
// predictor turns every accepted request into the bus beats it should
// cause; each outgoing beat is compared field by field with the oldest
// prediction. Directed requests cover the power-on sequence, long and short
// commands, characters, text strings with their corner cases and one long
// output hold-off; random traffic then runs under several wait-register
// settings while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer
    import lcdws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_BEATS      = 17;
    localparam int ITEM_TARGET    = 320;
    localparam int MAX_PRINTED    = 30;

    // Output side stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } t_rx_mode;

    // One bus beat as the block should send it
    typedef struct {
        logic        enable;
        logic        rs;
        logic [7:0]  data;
        logic [15:0] hold_us;
        logic        is_last;
    } t_lcd_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;  // payload_byte[7:0], row[9:8], column[14:10], fill_line[15]
    logic [1:0]  s_axis_tuser;  // opcode[1:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // bus_data[7:0], wait_us[23:8]
    logic [1:0]  m_axis_tuser;  // strobe_res[0], register_select[1]
    logic        m_axis_tlast;

    // Predicted beats in send order, and scratch for one request
    t_lcd_beat lcd_beats_due[$];
    t_lcd_beat request_beats[$];
    t_lcd_beat beat_due;

    // Predictor copy of the wait registers and the string state
    logic [15:0]      short_wait;
    logic [15:0]      long_wait;
    logic [15:0]      char_wait;
    logic             str_open;
    logic             str_ended;
    logic             str_dropped;
    logic [REM_W-1:0] chars_owed;

    // Sender burst state and output hold request
    int burst_left;
    bit hold_request;

    // Run statistics
    int mismatch_count;
    int requests_sent;
    int requests_with_beats;
    int beats_checked;
    int strings_started;
    int strings_rejected;
    int settings_used;

    char_lcd_write_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_beat(input logic enable, input logic rs,
                                     input logic [7:0] data, input logic [15:0] hold_us);
        t_lcd_beat b;
        if (request_beats.size() >= MAX_BEATS) begin
            return;
        end
        b.enable  = enable;
        b.rs      = rs;
        b.data    = data;
        b.hold_us = hold_us;
        b.is_last = 1'b0;
        request_beats.push_back(b);
    endfunction

    // Clear and home (bits 7..2 all zero) take the long settle time
    function automatic void add_command(input logic [7:0] cmd);
        add_beat(1'b1, 1'b0, cmd, ((cmd & CMD_LONG_MSK) == 8'h00) ? long_wait : short_wait);
    endfunction

    function automatic void add_character(input logic [7:0] ch);
        add_beat(1'b1, 1'b1, ch, char_wait);
    endfunction

    // Fill the rest of the line with spaces
    function automatic void pad_with_spaces();
        while (chars_owed != '0) begin
            add_character(CHAR_SPACE);
            chars_owed--;
        end
    endfunction

    function automatic void model_reset();
        short_wait  = SHORT_WAIT_RST;
        long_wait   = LONG_WAIT_RST;
        char_wait   = CHAR_WAIT_RST;
        str_open    = 1'b0;
        str_ended   = 1'b0;
        str_dropped = 1'b0;
        chars_owed  = '0;
    endfunction

    function automatic void predict_text(input logic [7:0] pay, input logic [1:0] row,
                                         input logic [4:0] col, input logic fill,
                                         input logic is_last);
        // First item of a string positions the cursor or rejects the string
        if (!str_open) begin
            str_open    = 1'b1;
            str_ended   = 1'b0;
            str_dropped = 1'b0;
            chars_owed  = '0;
            strings_started++;
            if (row > 2'd1 || int'(col) > LINE_CHARS - 1) begin
                str_dropped = 1'b1;
                strings_rejected++;
            end else begin
                add_command(CMD_DDRAM | ((row == 2'd1 ? ROW1_OFFSET : 8'h00) + {3'b000, col}));
                chars_owed = fill ? REM_W'(LINE_CHARS) : REM_W'(LINE_CHARS - int'(col));
            end
        end
        if (!str_dropped && !str_ended) begin
            if (pay == 8'h00) begin
                pad_with_spaces();
                str_ended = 1'b1;
            end else begin
                if (chars_owed != '0) begin
                    add_character(pay);
                    chars_owed--;
                end
                if (is_last) begin
                    pad_with_spaces();
                end
            end
        end
        if (is_last) begin
            str_open    = 1'b0;
            str_ended   = 1'b0;
            str_dropped = 1'b0;
            chars_owed  = '0;
        end
    endfunction

    // Build the beats of one accepted request and queue them
    function automatic void predict_request(input logic [1:0] op, input logic [7:0] pay,
                                            input logic [1:0] row, input logic [4:0] col,
                                            input logic fill, input logic is_last);
        request_beats.delete();
        case (op)
            OP_INIT: begin
                add_beat(1'b0, 1'b0, 8'h00, INIT_WAIT_US);
                add_beat(1'b1, 1'b0, CMD_FUNC_SET, RAW1_WAIT_US);
                add_beat(1'b1, 1'b0, CMD_FUNC_SET, RAW2_WAIT_US);
                add_command(CMD_FUNC_SET);
                add_command(CMD_DISP_ON);
                add_command(CMD_ENTRY);
                add_command(CMD_CLEAR);
            end
            OP_CMD:  add_command(pay);
            OP_CHAR: add_character(pay);
            default: predict_text(pay, row, col, fill, is_last);
        endcase
        if (request_beats.size() > 0) begin
            request_beats[request_beats.size() - 1].is_last = 1'b1;
            requests_with_beats++;
        end
        foreach (request_beats[k]) begin
            lcd_beats_due.push_back(request_beats[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one request; bursts of random length with random gaps between
    task automatic send_request(input logic [1:0] op, input logic [7:0] pay,
                                input logic [1:0] row, input logic [4:0] col,
                                input logic fill, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {fill, col, row, pay};
        s_axis_tuser  = op;
        s_axis_tlast  = is_last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        requests_sent++;
        predict_request(op, pay, row, col, fill, is_last);
    endtask

    // Request with the text-only fields randomized
    task automatic send_plain(input logic [1:0] op, input logic [7:0] pay);
        send_request(op, pay, 2'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Stop offering, let every predicted beat arrive, then let the block settle
    task automatic drain_outputs();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (lcd_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        @(posedge i_clk);
        case (index)
            CFG_SHORT_WAIT: short_wait = value;
            CFG_LONG_WAIT:  long_wait  = value;
            default:        char_wait  = value;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic apply_waits(input logic [15:0] short_us, input logic [15:0] long_us,
                               input logic [15:0] char_us);
        drain_outputs();
        write_register(CFG_SHORT_WAIT, short_us);
        write_register(CFG_LONG_WAIT, long_us);
        write_register(CFG_CHAR_WAIT, char_us);
        settings_used++;
    endtask

    // One string: mostly well formed, sometimes off-screen or cut by NUL
    task automatic send_random_string();
        int          len;
        int          nul_at;
        logic [1:0]  row;
        logic [4:0]  col;
        logic [7:0]  ch;
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
        row    = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        col    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                             : 5'($urandom_range(0, 15));
        nul_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            // Slip an unrelated request into the middle of the string now and then
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                send_plain(2'($urandom_range(OP_CMD, OP_CHAR)), 8'($urandom));
            end
            ch = (i == nul_at) ? 8'h00 : 8'($urandom_range(1, 255));
            if (i == 0) begin
                send_request(OP_TEXT, ch, row, col, 1'($urandom), i == len - 1);
            end else begin
                send_request(OP_TEXT, ch, 2'($urandom), 5'($urandom), 1'($urandom),
                             i == len - 1);
            end
        end
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_plain(OP_INIT, 8'($urandom));
        end else if (pick < 28) begin
            send_plain(OP_CMD, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                           : 8'($urandom));
        end else if (pick < 45) begin
            send_plain(OP_CHAR, 8'($urandom));
        end else begin
            send_random_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Power-on sequence, long and short commands, data characters
    task automatic test_power_on_and_commands();
        send_plain(OP_INIT, 8'h00);
        send_plain(OP_CMD, 8'h00);
        send_plain(OP_CMD, 8'h01);
        send_plain(OP_CMD, 8'h03);
        send_plain(OP_CMD, 8'h04);
        send_plain(OP_CMD, 8'hFF);
        send_plain(OP_CHAR, 8'h00);
        send_plain(OP_CHAR, 8'hFF);
        send_plain(OP_CHAR, 8'h41);
    endtask

    // Text strings: padding, blank fill, NUL end, rejection, overflow, interleave
    task automatic test_text_strings();
        // short string on line 0, padded to the line end
        send_request(OP_TEXT, 8'h48, 2'd0, 5'd0, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h69, 2'd3, 5'd31, 1'b1, 1'b1);
        // last column of line 1 with blank fill: one character, fifteen spaces
        send_request(OP_TEXT, 8'hFF, 2'd1, 5'd15, 1'b1, 1'b1);
        // NUL ends the string early, later items ignored
        send_request(OP_TEXT, 8'h41, 2'd1, 5'd3, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h42, 2'd0, 5'd0, 1'b0, 1'b1);
        // row out of range rejects the whole string
        send_request(OP_TEXT, 8'h43, 2'd2, 5'd0, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h44, 2'd0, 5'd0, 1'b0, 1'b1);
        // column out of range rejects a single-item string
        send_request(OP_TEXT, 8'h45, 2'd0, 5'd16, 1'b1, 1'b1);
        // command interleaved inside a string
        send_request(OP_TEXT, 8'h31, 2'd1, 5'd5, 1'b0, 1'b0);
        send_plain(OP_CMD, 8'h02);
        send_request(OP_TEXT, 8'h32, 2'd0, 5'd9, 1'b1, 1'b1);
        // more characters than the line holds: the extra one is dropped
        send_request(OP_TEXT, 8'h61, 2'd0, 5'd14, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h62, 2'd0, 5'd0, 1'b0, 1'b0);
        send_request(OP_TEXT, 8'h63, 2'd0, 5'd0, 1'b0, 1'b1);
    endtask

    // Long output hold-off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain_outputs();
        hold_request = 1'b1;
        send_plain(OP_INIT, 8'h00);
        send_request(OP_TEXT, 8'h5A, 2'd0, 5'd0, 1'b1, 1'b1);
        send_plain(OP_CMD, 8'h01);
        send_plain(OP_CHAR, 8'h7E);
        send_request(OP_TEXT, 8'h00, 2'd1, 5'd2, 1'b0, 1'b1);
        send_plain(OP_INIT, 8'hFF);
    endtask

    // Random traffic under a series of wait settings, extremes included
    task automatic test_random_traffic();
        logic [15:0] setting [6][3];
        int          phase_goal;
        setting[0] = '{16'd0, 16'd0, 16'd0};
        setting[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        setting[2] = '{16'd1, 16'hFFFE, 16'h8000};
        setting[3] = '{16'($urandom), 16'($urandom), 16'($urandom)};
        setting[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
        setting[5] = '{SHORT_WAIT_RST, LONG_WAIT_RST, CHAR_WAIT_RST};
        for (int p = 0; p < 6; p++) begin
            apply_waits(setting[p][0], setting[p][1], setting[p][2]);
            phase_goal = requests_sent + (ITEM_TARGET - requests_sent) / (6 - p);
            while (requests_sent < phase_goal) begin
                send_random_request();
            end
            // Close any open string so the next phase starts clean
            if (str_open) begin
                send_request(OP_TEXT, 8'($urandom), 2'($urandom), 5'($urandom),
                             1'($urandom), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall patterns and the long hold-off
    // ------------------------------------------------------------------
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       tick;
        m_axis_tready = 1'b0;
        rx_mode       = RX_OPEN;
        mode_left     = 0;
        tick          = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(RX_OPEN, RX_CADENCE));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready = 1'b1;
                    RX_COIN:   m_axis_tready = 1'($urandom);
                    RX_SPARSE: m_axis_tready = ($urandom_range(0, 7) != 0);
                    default:   m_axis_tready = (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] beat %0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, beats_checked, what, got, want);
        end
    endtask

    // Compare every accepted beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (lcd_beats_due.size() == 0) begin
                report_mismatch("with nothing predicted, data", m_axis_tdata, 0);
            end else begin
                beat_due = lcd_beats_due.pop_front();
                if (m_axis_tuser[0] !== beat_due.enable)
                    report_mismatch("strobe", m_axis_tuser[0], beat_due.enable);
                if (m_axis_tuser[1] !== beat_due.rs)
                    report_mismatch("register select", m_axis_tuser[1], beat_due.rs);
                if (m_axis_tdata[7:0] !== beat_due.data)
                    report_mismatch("bus data", m_axis_tdata[7:0], beat_due.data);
                if (m_axis_tdata[23:8] !== beat_due.hold_us)
                    report_mismatch("wait_us", m_axis_tdata[23:8], beat_due.hold_us);
                if (m_axis_tlast !== beat_due.is_last)
                    report_mismatch("last", m_axis_tlast, beat_due.is_last);
            end
            beats_checked++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[%0t] no beat moved for %0d cycles, %0d beats still predicted",
                 $realtime, WATCHDOG_LIMIT, lcd_beats_due.size());
        $display("** char_lcd_write_sequencer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_SHORT_WAIT;
        i_cfg_wdata   = 16'h0000;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        s_axis_tuser  = OP_INIT;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        hold_request  = 1'b0;
        mismatch_count      = 0;
        requests_sent       = 0;
        requests_with_beats = 0;
        beats_checked       = 0;
        strings_started     = 0;
        strings_rejected    = 0;
        settings_used       = 1;
        model_reset();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_on_and_commands();
        test_text_strings();
        test_output_backpressure();
        test_random_traffic();
        drain_outputs();

        $display("Sent %0d requests (%0d with bus output, %0d strings, %0d rejected), %0d beats",
                 requests_sent, requests_with_beats, strings_started, strings_rejected,
                 beats_checked);
        $display("across %0d wait settings, with one %0d-cycle output hold-off",
                 settings_used, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("** char_lcd_write_sequencer: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** char_lcd_write_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
